// ===== src/acfp_pkg.sv =====
// Shared constants, types and keyword tables for the ASCII command frame parser.
`timescale 1ns / 1ps
`default_nettype none
package acfp_pkg;

	localparam int FRAME_LIMIT = 96;
	localparam int LEN_W       = $clog2(FRAME_LIMIT);
	localparam int QUEUE_SLOTS = 6;
	localparam int QPTR_W      = $clog2(QUEUE_SLOTS);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] SPEED_MAX = 8'd255;

	// keyword indexes into the candidate vector
	localparam int KW_START = 0;
	localparam int KW_STOP  = 1;
	localparam int KW_ESTOP = 2;
	localparam int KW_HOME  = 3;
	localparam int KW_OK    = 4;
	localparam int KW_SPD   = 5;
	localparam int KW_MAN   = 6;
	localparam int KW_GET   = 7;
	localparam int KW_RESET = 8;
	localparam int KW_Z     = 9;
	localparam int KW_PUMP  = 10;
	localparam int KW_PG    = 11;
	localparam int KW_STATE = 12;
	localparam int KW_UP    = 13;
	localparam int KW_DOWN  = 14;
	localparam int KW_IN    = 15;
	localparam int KW_OUT   = 16;
	localparam int KW_N     = 17;
	localparam int KW_IDX_W = $clog2(KW_N);

	typedef enum logic [3:0] {
		CMD_START     = 4'd0,
		CMD_STOP      = 4'd1,
		CMD_ESTOP     = 4'd2,
		CMD_HOME      = 4'd3,
		CMD_OK        = 4'd4,
		CMD_SPEED_SET = 4'd5,
		CMD_MANUAL    = 4'd6,
		CMD_GET_PG    = 4'd7,
		CMD_GET_STATE = 4'd8,
		CMD_RESET     = 4'd9
	} cmd_type_e;

	typedef enum logic [2:0] {
		ACT_UP   = 3'd0,
		ACT_DOWN = 3'd1,
		ACT_STOP = 3'd2,
		ACT_IN   = 3'd3,
		ACT_OUT  = 3'd4
	} act_e;

	localparam logic TGT_Z    = 1'b0;
	localparam logic TGT_PUMP = 1'b1;

	typedef enum logic [1:0] {
		NUM_WS,
		NUM_DIG,
		NUM_DONE
	} num_phase_e;

	typedef struct packed {
		logic       op;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  cmd_type;
		logic [15:0] volume;
		logic        keep_level;
		logic [7:0]  speed;
		logic        man_tgt;
		logic [2:0]  man_act;
	} cmd_t;

	typedef struct packed {
		logic        pop_valid;
		logic [3:0]  cmd_type;
		logic [15:0] volume;
		logic        keep_level;
		logic [7:0]  speed;
		logic        man_tgt;
		logic [2:0]  man_act;
		logic        push_dropped;
	} result_t;

	// classified beat passed from the parser to the command queue
	typedef struct packed {
		logic is_pop;
		logic push_valid;
		cmd_t cmd;
	} mid_t;

	function automatic logic [2:0] kw_len(input logic [KW_IDX_W-1:0] k);
		logic [2:0] l;
		case (k)
			KW_IDX_W'(KW_START): l = 3'd5;
			KW_IDX_W'(KW_STOP):  l = 3'd4;
			KW_IDX_W'(KW_ESTOP): l = 3'd5;
			KW_IDX_W'(KW_HOME):  l = 3'd4;
			KW_IDX_W'(KW_OK):    l = 3'd2;
			KW_IDX_W'(KW_SPD):   l = 3'd3;
			KW_IDX_W'(KW_MAN):   l = 3'd3;
			KW_IDX_W'(KW_GET):   l = 3'd3;
			KW_IDX_W'(KW_RESET): l = 3'd5;
			KW_IDX_W'(KW_Z):     l = 3'd1;
			KW_IDX_W'(KW_PUMP):  l = 3'd4;
			KW_IDX_W'(KW_PG):    l = 3'd2;
			KW_IDX_W'(KW_STATE): l = 3'd5;
			KW_IDX_W'(KW_UP):    l = 3'd2;
			KW_IDX_W'(KW_DOWN):  l = 3'd4;
			KW_IDX_W'(KW_IN):    l = 3'd2;
			KW_IDX_W'(KW_OUT):   l = 3'd3;
			default:             l = 3'd0;
		endcase
		return l;
	endfunction

	// keyword text, right aligned, last character in the low byte
	function automatic logic [39:0] kw_text(input logic [KW_IDX_W-1:0] k);
		logic [39:0] t;
		case (k)
			KW_IDX_W'(KW_START): t = 40'("START");
			KW_IDX_W'(KW_STOP):  t = 40'("STOP");
			KW_IDX_W'(KW_ESTOP): t = 40'("ESTOP");
			KW_IDX_W'(KW_HOME):  t = 40'("HOME");
			KW_IDX_W'(KW_OK):    t = 40'("OK");
			KW_IDX_W'(KW_SPD):   t = 40'("SPD");
			KW_IDX_W'(KW_MAN):   t = 40'("MAN");
			KW_IDX_W'(KW_GET):   t = 40'("GET");
			KW_IDX_W'(KW_RESET): t = 40'("RESET");
			KW_IDX_W'(KW_Z):     t = 40'("Z");
			KW_IDX_W'(KW_PUMP):  t = 40'("PUMP");
			KW_IDX_W'(KW_PG):    t = 40'("PG");
			KW_IDX_W'(KW_STATE): t = 40'("STATE");
			KW_IDX_W'(KW_UP):    t = 40'("UP");
			KW_IDX_W'(KW_DOWN):  t = 40'("DOWN");
			KW_IDX_W'(KW_IN):    t = 40'("IN");
			KW_IDX_W'(KW_OUT):   t = 40'("OUT");
			default:             t = '0;
		endcase
		return t;
	endfunction

	// character p of keyword k; only meaningful for p below its length
	function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k, input logic [2:0] p);
		logic [39:0] t;
		logic [2:0]  sh;
		t  = kw_text(k);
		sh = kw_len(k) - 3'd1 - p;
		return t[{sh, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== src/ascii_command_frame_parser.sv =====
// Top level of the ASCII command frame parser with its command queue.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat is either a received byte (op 0) or a pop request (op 1), and
// every beat yields exactly one result beat, in order. Bytes build frames
// "#field,field,...;" - '#' (re)starts a frame, ';' ends and decodes it, a NUL
// ends the content early, and a frame longer than FRAME_LIMIT-1 content bytes
// is dropped. Decoded commands enter a QUEUE_SLOTS-slot ring holding
// QUEUE_SLOTS-1 commands; a byte that completes a command while the ring is full
// reports push_dropped. A pop beat returns the oldest command with pop_valid set,
// or all zeros when the ring is empty. The block takes one beat per clock while
// full is low: the parser classifies each byte in the cycle it is accepted, from
// its running field state, a two-entry queue hands classified beats to the ring
// stage, and a two-entry result queue lets the block keep taking beats while
// results wait. An accepted beat is registered into the classified-beat queue,
// and its result then into the result queue, which drops empty.
module ascii_command_frame_parser import acfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic emit;
	mid_t emit_item;

	// parse and classify each beat
	acfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.stall     (full),
		.emit      (emit),
		.emit_item (emit_item)
	);

	// queue commands and answer pops
	acfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.emit_item (emit_item),
		.mid_full  (full),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
`default_nettype wire

// ===== src/acfp_front.sv =====
// Byte parser: frame tracking, field splitting, keyword matching, number reading, decode.
`timescale 1ns / 1ps
`default_nettype none
module acfp_front import acfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	input  logic  stall,
	output logic  emit,
	output mid_t  emit_item
);

	logic             in_frame_q;
	logic [LEN_W-1:0] len_q;
	logic             ended_q;
	logic [2:0]       cnt_q;
	logic [LEN_W-1:0] pos_q;
	logic [KW_N-1:0]  cand_q;
	logic [31:0]      mag_q;
	logic             neg_q;
	num_phase_e       nph_q;

	logic [KW_N-1:0]  f0m_q, f1m_q, f2m_q;
	logic [15:0]      f1vol_q;
	logic [7:0]       f1spd_q, f3spd_q;
	logic             f2pos_q;

	logic [7:0] b;
	logic       accept, is_byte;
	logic       is_hash, is_semi, is_comma, is_nul, is_ws, is_digit, is_sign;
	logic       fin;

	assign b        = item.byte_value;
	assign accept   = push && !stall;
	assign is_byte  = accept && !item.op;
	assign is_hash  = b == CH_HASH;
	assign is_semi  = b == CH_SEMI;
	assign is_comma = b == CH_COMMA;
	assign is_nul   = b == CH_NUL;
	assign is_ws    = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	assign is_digit = b >= CH_ZERO && b <= CH_NINE;
	assign is_sign  = b == CH_PLUS || b == CH_MINUS;
	assign fin      = pos_q != '0;

	// close out the field in progress
	logic [KW_N-1:0] cur_match;
	logic [15:0]     cur_vol;
	logic [7:0]      cur_spd;
	logic            cur_pos;

	always_comb begin
		for (int k = 0; k < KW_N; k++) begin
			cur_match[k] = cand_q[k] && (pos_q == LEN_W'(kw_len(KW_IDX_W'(k))));
		end
		if (neg_q) begin
			cur_vol = ~mag_q[15:0] + 16'd1;
		end else if (mag_q[31]) begin
			cur_vol = 16'hFFFF;
		end else begin
			cur_vol = mag_q[15:0];
		end
		if (neg_q) begin
			cur_spd = '0;
		end else if (mag_q > 32'(SPEED_MAX)) begin
			cur_spd = SPEED_MAX;
		end else begin
			cur_spd = mag_q[7:0];
		end
		cur_pos = !neg_q && mag_q != '0;
	end

	// keyword candidates after this character
	logic [KW_N-1:0] base_cand, next_cand;
	always_comb begin
		base_cand = fin ? cand_q : '1;
		for (int k = 0; k < KW_N; k++) begin
			next_cand[k] = base_cand[k]
				&& (pos_q < LEN_W'(kw_len(KW_IDX_W'(k))))
				&& (kw_char(KW_IDX_W'(k), pos_q[2:0]) == b);
		end
	end

	// number reader: next state
	num_phase_e base_phase, next_phase;
	assign base_phase = fin ? nph_q : NUM_WS;

	always_comb begin
		case (base_phase)
			NUM_WS: begin
				if (is_ws) next_phase = NUM_WS;
				else if (is_sign || is_digit) next_phase = NUM_DIG;
				else next_phase = NUM_DONE;
			end
			NUM_DIG: next_phase = is_digit ? NUM_DIG : NUM_DONE;
			default: next_phase = NUM_DONE;
		endcase
	end

	// number reader: outputs
	logic [31:0] base_mag, next_mag;
	logic        base_neg, next_neg;
	logic [35:0] prod;

	assign base_mag = fin ? mag_q : '0;
	assign base_neg = fin ? neg_q : 1'b0;
	assign prod     = ({4'b0, base_mag} << 3) + ({4'b0, base_mag} << 1) + 36'(b[3:0]);

	always_comb begin
		next_mag = base_mag;
		next_neg = base_neg;
		case (base_phase)
			NUM_WS: begin
				if (is_sign) next_neg = b == CH_MINUS;
				else if (is_digit) next_mag = prod > 36'h080000000 ? 32'h80000000 : prod[31:0];
			end
			NUM_DIG: begin
				if (is_digit) next_mag = prod > 36'h080000000 ? 32'h80000000 : prod[31:0];
			end
			default: ;
		endcase
	end

	// effective fields at end of frame
	logic [2:0]      n_eff;
	logic [KW_N-1:0] e0m, e1m, e2m;
	logic [15:0]     e1vol;
	logic [7:0]      e1spd, e3spd;
	logic            e2pos;

	always_comb begin
		n_eff = (fin && cnt_q < 3'd4) ? cnt_q + 3'd1 : cnt_q;
		e0m   = (fin && cnt_q == 3'd0) ? cur_match : f0m_q;
		e1m   = (fin && cnt_q == 3'd1) ? cur_match : f1m_q;
		e1vol = (fin && cnt_q == 3'd1) ? cur_vol : f1vol_q;
		e1spd = (fin && cnt_q == 3'd1) ? cur_spd : f1spd_q;
		e2m   = (fin && cnt_q == 3'd2) ? cur_match : f2m_q;
		e2pos = (fin && cnt_q == 3'd2) ? cur_pos : f2pos_q;
		e3spd = (fin && cnt_q == 3'd3) ? cur_spd : f3spd_q;
	end

	logic dec_valid;
	cmd_t dec_cmd;

	always_comb begin
		dec_valid = 1'b0;
		dec_cmd   = '0;
		if (e0m[KW_START]) begin
			dec_valid          = n_eff >= 3'd2;
			dec_cmd.cmd_type   = CMD_START;
			dec_cmd.volume     = e1vol;
			dec_cmd.keep_level = n_eff >= 3'd3 && e2pos;
		end else if (e0m[KW_STOP]) begin
			dec_valid        = 1'b1;
			dec_cmd.cmd_type = CMD_STOP;
		end else if (e0m[KW_ESTOP]) begin
			dec_valid        = 1'b1;
			dec_cmd.cmd_type = CMD_ESTOP;
		end else if (e0m[KW_HOME]) begin
			dec_valid        = 1'b1;
			dec_cmd.cmd_type = CMD_HOME;
		end else if (e0m[KW_OK]) begin
			dec_valid        = 1'b1;
			dec_cmd.cmd_type = CMD_OK;
		end else if (e0m[KW_SPD]) begin
			dec_valid        = n_eff >= 3'd2;
			dec_cmd.cmd_type = CMD_SPEED_SET;
			dec_cmd.speed    = e1spd;
		end else if (e0m[KW_MAN]) begin
			dec_cmd.cmd_type = CMD_MANUAL;
			dec_cmd.speed    = n_eff >= 3'd4 ? e3spd : '0;
			if (e1m[KW_Z]) begin
				dec_cmd.man_tgt = TGT_Z;
				dec_valid = e2m[KW_UP] || e2m[KW_DOWN] || e2m[KW_STOP];
				if (e2m[KW_UP]) dec_cmd.man_act = ACT_UP;
				else if (e2m[KW_DOWN]) dec_cmd.man_act = ACT_DOWN;
				else dec_cmd.man_act = ACT_STOP;
			end else if (e1m[KW_PUMP]) begin
				dec_cmd.man_tgt = TGT_PUMP;
				dec_valid = e2m[KW_IN] || e2m[KW_OUT] || e2m[KW_STOP];
				if (e2m[KW_IN]) dec_cmd.man_act = ACT_IN;
				else if (e2m[KW_OUT]) dec_cmd.man_act = ACT_OUT;
				else dec_cmd.man_act = ACT_STOP;
			end
			if (n_eff < 3'd3) dec_valid = 1'b0;
		end else if (e0m[KW_GET]) begin
			dec_valid        = n_eff >= 3'd2 && (e1m[KW_PG] || e1m[KW_STATE]);
			dec_cmd.cmd_type = e1m[KW_PG] ? CMD_GET_PG : CMD_GET_STATE;
		end else if (e0m[KW_RESET]) begin
			dec_valid        = 1'b1;
			dec_cmd.cmd_type = CMD_RESET;
		end
	end

	// a frame with no fields at all decodes to nothing
	assign emit                 = accept;
	assign emit_item.is_pop     = item.op;
	assign emit_item.push_valid = !item.op && !is_hash && in_frame_q && is_semi && dec_valid
		&& n_eff != 3'd0;
	assign emit_item.cmd        = dec_cmd;

	logic content;
	assign content = is_byte && !is_hash && in_frame_q && !is_semi
		&& len_q != LEN_W'(FRAME_LIMIT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_q      <= '0;
			ended_q    <= 1'b0;
			cnt_q      <= '0;
			pos_q      <= '0;
			cand_q     <= '1;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			nph_q      <= NUM_WS;
		end else if (is_byte) begin
			if (is_hash) begin
				in_frame_q <= 1'b1;
				len_q      <= '0;
				ended_q    <= 1'b0;
				cnt_q      <= '0;
				pos_q      <= '0;
			end else if (in_frame_q) begin
				if (is_semi || len_q == LEN_W'(FRAME_LIMIT - 1)) begin
					in_frame_q <= 1'b0;
					len_q      <= '0;
				end else begin
					len_q <= len_q + LEN_W'(1);
					if (!ended_q) begin
						if (is_comma || is_nul) begin
							pos_q <= '0;
							if (fin && cnt_q < 3'd4) cnt_q <= cnt_q + 3'd1;
							if (is_nul) ended_q <= 1'b1;
						end else begin
							pos_q  <= pos_q + LEN_W'(1);
							cand_q <= next_cand;
							mag_q  <= next_mag;
							neg_q  <= next_neg;
							nph_q  <= next_phase;
						end
					end
				end
			end
		end
	end

	// store a finished field by its index
	always_ff @(posedge clk) begin
		if (content && !ended_q && (is_comma || is_nul) && fin) begin
			case (cnt_q)
				3'd0: f0m_q <= cur_match;
				3'd1: begin
					f1m_q   <= cur_match;
					f1vol_q <= cur_vol;
					f1spd_q <= cur_spd;
				end
				3'd2: begin
					f2m_q   <= cur_match;
					f2pos_q <= cur_pos;
				end
				3'd3: f3spd_q <= cur_spd;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/acfp_back.sv =====
// Command queue side: decoupling queue, command ring and result queue.
`timescale 1ns / 1ps
`default_nettype none
module acfp_back import acfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    emit,
	input  mid_t    emit_item,
	output logic    mid_full,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	mid_t       mq_q [2];
	logic       mwr_q, mrd_q;
	logic [1:0] mcnt_q;

	result_t    oq_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;

	cmd_t              ring_q [QUEUE_SLOTS];
	logic [QPTR_W-1:0] head_q, tail_q, head_nxt, tail_nxt;

	mid_t    mid_head;
	logic    opop, proc, ring_empty, ring_full, ring_wr;
	result_t res;
	cmd_t    rd;

	assign mid_full   = mcnt_q == 2'd2;
	assign mid_head   = mq_q[mrd_q];
	assign empty      = ocnt_q == 2'd0;
	assign result     = oq_q[ord_q];
	assign opop       = pop && !empty;
	assign proc       = mcnt_q != 2'd0 && (ocnt_q != 2'd2 || opop);

	assign head_nxt   = head_q == QPTR_W'(QUEUE_SLOTS - 1) ? '0 : head_q + QPTR_W'(1);
	assign tail_nxt   = tail_q == QPTR_W'(QUEUE_SLOTS - 1) ? '0 : tail_q + QPTR_W'(1);
	assign ring_empty = head_q == tail_q;
	assign ring_full  = head_nxt == tail_q;
	assign ring_wr    = proc && !mid_head.is_pop && mid_head.push_valid && !ring_full;
	assign rd         = ring_q[tail_q];

	always_comb begin
		res = '0;
		if (mid_head.is_pop) begin
			if (!ring_empty) begin
				res.pop_valid  = 1'b1;
				res.cmd_type   = rd.cmd_type;
				res.volume     = rd.volume;
				res.keep_level = rd.keep_level;
				res.speed      = rd.speed;
				res.man_tgt    = rd.man_tgt;
				res.man_act    = rd.man_act;
			end
		end else if (mid_head.push_valid && ring_full) begin
			res.push_dropped = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mwr_q  <= 1'b0;
			mrd_q  <= 1'b0;
			mcnt_q <= '0;
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (emit) mwr_q <= !mwr_q;
			if (proc) mrd_q <= !mrd_q;
			mcnt_q <= mcnt_q + {1'b0, emit} - {1'b0, proc};
			if (proc) owr_q <= !owr_q;
			if (opop) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + {1'b0, proc} - {1'b0, opop};
			if (ring_wr) head_q <= head_nxt;
			if (proc && mid_head.is_pop && !ring_empty) tail_q <= tail_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) mq_q[mwr_q] <= emit_item;
		if (proc) oq_q[owr_q] <= res;
		if (ring_wr) ring_q[head_q] <= mid_head.cmd;
	end

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q != 2'd3 && ocnt_q != 2'd3)
		else $error("queue count out of range");

	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < QPTR_W'(QUEUE_SLOTS) && tail_q < QPTR_W'(QUEUE_SLOTS))
		else $error("ring pointer out of range");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !mid_head.is_pop && mid_head.push_valid && ring_full) |=> $stable(head_q))
		else $error("ring head moved on a dropped command");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && mid_head.is_pop && ring_empty) |=> $stable(tail_q))
		else $error("ring tail moved on a pop of an empty ring");

endmodule
`default_nettype wire

// ===== test/acfp_checker.sv =====
// Scoreboard for the ASCII command frame parser: predicts every result beat and compares it.
`timescale 1ns / 1ps
module acfp_checker import acfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      pending,
	output int      popped_cmds,
	output int      dropped_cmds
);

	localparam int MAX_FIELDS = 8;

	logic [7:0] frame_bytes[$];
	logic       in_frame;
	cmd_t       cmd_ring[$];
	result_t    expected_results[$];

	int tok_start[MAX_FIELDS];
	int tok_len[MAX_FIELDS];
	int tok_count;

	function automatic bit token_is(int s, int l, string kw);
		if (l != kw.len())
			return 0;
		for (int k = 0; k < l; k++)
			if (frame_bytes[s + k] != kw[k])
				return 0;
		return 1;
	endfunction

	// atoi-style read, saturated to the signed 32-bit range
	function automatic longint field_number(int s, int l);
		int     i;
		int     stop;
		bit     neg;
		longint mag;
		i = s;
		stop = s + l;
		neg = 0;
		mag = 0;
		while (i < stop && (frame_bytes[i] == CH_SPACE ||
			(frame_bytes[i] >= CH_TAB && frame_bytes[i] <= CH_CR)))
			i++;
		if (i < stop && (frame_bytes[i] == CH_PLUS || frame_bytes[i] == CH_MINUS)) begin
			neg = frame_bytes[i] == CH_MINUS;
			i++;
		end
		while (i < stop && frame_bytes[i] >= CH_ZERO && frame_bytes[i] <= CH_NINE) begin
			mag = mag * 10 + (frame_bytes[i] - CH_ZERO);
			if (mag > 64'd2147483648)
				mag = 64'd2147483648;
			i++;
		end
		if (neg)
			return -mag;
		return (mag > 64'd2147483647) ? 64'd2147483647 : mag;
	endfunction

	function automatic logic [7:0] clamp_speed(longint v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return SPEED_MAX;
		return v[7:0];
	endfunction

	// decode the held frame; returns 1 with the command if it is valid
	function automatic bit decode_frame(output cmd_t c);
		int     n;
		int     i;
		int     len;
		int     s;
		longint v;
		c = '0;
		len = 0;
		while (len < frame_bytes.size() && frame_bytes[len] != CH_NUL)
			len++;
		n = 0;
		i = 0;
		while (i < len && n < MAX_FIELDS) begin
			if (frame_bytes[i] == CH_COMMA) begin
				i++;
			end else begin
				s = i;
				while (i < len && frame_bytes[i] != CH_COMMA)
					i++;
				tok_start[n] = s;
				tok_len[n] = i - s;
				n++;
			end
		end
		if (n == 0)
			return 0;
		if (token_is(tok_start[0], tok_len[0], "START")) begin
			if (n < 2)
				return 0;
			c.cmd_type = CMD_START;
			v = field_number(tok_start[1], tok_len[1]);
			c.volume = v[15:0];
			if (n >= 3)
				c.keep_level = field_number(tok_start[2], tok_len[2]) > 0;
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "STOP")) begin
			c.cmd_type = CMD_STOP;
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "ESTOP")) begin
			c.cmd_type = CMD_ESTOP;
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "HOME")) begin
			c.cmd_type = CMD_HOME;
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "OK")) begin
			c.cmd_type = CMD_OK;
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "SPD")) begin
			if (n < 2)
				return 0;
			c.cmd_type = CMD_SPEED_SET;
			c.speed = clamp_speed(field_number(tok_start[1], tok_len[1]));
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "MAN")) begin
			if (n < 3)
				return 0;
			c.cmd_type = CMD_MANUAL;
			if (token_is(tok_start[1], tok_len[1], "Z")) begin
				c.man_tgt = TGT_Z;
				if (token_is(tok_start[2], tok_len[2], "UP"))
					c.man_act = ACT_UP;
				else if (token_is(tok_start[2], tok_len[2], "DOWN"))
					c.man_act = ACT_DOWN;
				else if (token_is(tok_start[2], tok_len[2], "STOP"))
					c.man_act = ACT_STOP;
				else
					return 0;
			end else if (token_is(tok_start[1], tok_len[1], "PUMP")) begin
				c.man_tgt = TGT_PUMP;
				if (token_is(tok_start[2], tok_len[2], "IN"))
					c.man_act = ACT_IN;
				else if (token_is(tok_start[2], tok_len[2], "OUT"))
					c.man_act = ACT_OUT;
				else if (token_is(tok_start[2], tok_len[2], "STOP"))
					c.man_act = ACT_STOP;
				else
					return 0;
			end else begin
				return 0;
			end
			if (n >= 4)
				c.speed = clamp_speed(field_number(tok_start[3], tok_len[3]));
			return 1;
		end
		if (token_is(tok_start[0], tok_len[0], "GET")) begin
			if (n < 2)
				return 0;
			if (token_is(tok_start[1], tok_len[1], "PG")) begin
				c.cmd_type = CMD_GET_PG;
				return 1;
			end
			if (token_is(tok_start[1], tok_len[1], "STATE")) begin
				c.cmd_type = CMD_GET_STATE;
				return 1;
			end
			return 0;
		end
		if (token_is(tok_start[0], tok_len[0], "RESET")) begin
			c.cmd_type = CMD_RESET;
			return 1;
		end
		return 0;
	endfunction

	function automatic result_t predict_beat(item_t it);
		result_t r;
		cmd_t    c;
		r = '0;
		if (it.op) begin
			if (cmd_ring.size() > 0) begin
				c = cmd_ring.pop_front();
				r.pop_valid  = 1'b1;
				r.cmd_type   = c.cmd_type;
				r.volume     = c.volume;
				r.keep_level = c.keep_level;
				r.speed      = c.speed;
				r.man_tgt    = c.man_tgt;
				r.man_act    = c.man_act;
			end
		end else if (it.byte_value == CH_HASH) begin
			in_frame = 1;
			frame_bytes.delete();
		end else if (in_frame) begin
			if (it.byte_value == CH_SEMI) begin
				if (decode_frame(c)) begin
					if (cmd_ring.size() == QUEUE_SLOTS - 1)
						r.push_dropped = 1'b1;
					else
						cmd_ring.push_back(c);
				end
				in_frame = 0;
				frame_bytes.delete();
			end else if (frame_bytes.size() < FRAME_LIMIT - 1) begin
				frame_bytes.push_back(it.byte_value);
			end else begin
				// overlong frame: lose this byte and wait for the next '#'
				in_frame = 0;
				frame_bytes.delete();
			end
		end
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		popped_cmds = 0;
		dropped_cmds = 0;
		in_frame = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (push && !full)
				expected_results.push_back(predict_beat(item));
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report("unexpected result beat, pop_valid", result.pop_valid, 0);
				end else begin
					want = expected_results.pop_front();
					popped_cmds += want.pop_valid;
					dropped_cmds += want.push_dropped;
					if (result.pop_valid !== want.pop_valid)
						report("pop_valid", result.pop_valid, want.pop_valid);
					if (result.cmd_type !== want.cmd_type)
						report("cmd_type", result.cmd_type, want.cmd_type);
					if (result.volume !== want.volume)
						report("volume", result.volume, want.volume);
					if (result.keep_level !== want.keep_level)
						report("keep_level", result.keep_level, want.keep_level);
					if (result.speed !== want.speed)
						report("speed", result.speed, want.speed);
					if (result.man_tgt !== want.man_tgt)
						report("man_tgt", result.man_tgt, want.man_tgt);
					if (result.man_act !== want.man_act)
						report("man_act", result.man_act, want.man_act);
					if (result.push_dropped !== want.push_dropped)
						report("push_dropped", result.push_dropped, want.push_dropped);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== test/ascii_command_frame_parser_tb.sv =====
// Testbench top for the ASCII command frame parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module ascii_command_frame_parser_tb;
	import acfp_pkg::*;

	localparam int ITEM_TARGET = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	int errors;
	int pending;
	int popped_cmds;
	int dropped_cmds;

	int beats_sent;
	int burst_left;
	int frames_sent;
	int cycles;
	bit hold_req;

	ascii_command_frame_parser dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	acfp_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .errors(errors),
		.pending(pending), .popped_cmds(popped_cmds), .dropped_cmds(dropped_cmds)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: vary the pop pattern in stretches; once, hold off long enough
	// that the block backs up and drops full on the sender.
	initial begin
		int mode;
		int left;
		bit held;
		pop = 1'b0;
		held = 0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				pop <= 1'b0;
				for (int k = 0; k < LONG_HOLD; k++)
					@(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 60);
				end
				left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offer one beat and hold it until taken; drop push only at a burst end.
	task automatic send_beat(logic is_pop, logic [7:0] b);
		bit taken;
		item_t it;
		it.op = is_pop;
		it.byte_value = b;
		push <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 2) == 0) ? 40 : $urandom_range(0, 8);
			if ($urandom_range(0, 2) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(1'b0, s[i]);
	endtask

	function automatic string rand_number();
		string s;
		s = "";
		repeat ($urandom_range(0, 2))
			s = {s, ($urandom_range(0, 1) != 0) ? " " : "\t"};
		case ($urandom_range(0, 3))
			0: s = {s, "-"};
			1: s = {s, "+"};
			default: ;
		endcase
		repeat ($urandom_range(0, ($urandom_range(0, 3) == 0) ? 14 : 4))
			s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_frame_body();
		string s;
		case ($urandom_range(0, 12))
			0: s = {"START,", rand_number()};
			1: s = {"START,", rand_number(), ",", rand_number()};
			2: s = "STOP";
			3: s = "ESTOP";
			4: s = "HOME";
			5: s = "OK";
			6: s = {"SPD,", rand_number()};
			7: s = ($urandom_range(0, 1) != 0) ? "GET,PG" : "GET,STATE";
			8: s = "RESET";
			9: s = "MAN,Z,UP";
			10: s = {"MAN,Z,", ($urandom_range(0, 1) != 0) ? "DOWN," : "STOP,", rand_number()};
			11: s = {"MAN,PUMP,", ($urandom_range(0, 1) != 0) ? "IN" : "OUT"};
			default: s = {"MAN,PUMP,STOP,", rand_number()};
		endcase
		// spice: stray commas, trailing surplus fields, truncation
		if ($urandom_range(0, 5) == 0)
			s = {",,", s, ","};
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 9))
				s = {s, ",", rand_number()};
		if ($urandom_range(0, 9) == 0 && s.len() > 1)
			s = s.substr(0, $urandom_range(0, s.len() - 2));
		return s;
	endfunction

	// One frame: mostly clean, sometimes corrupted, overlong, NUL-cut or headless.
	task automatic send_frame();
		string body;
		int    kind;
		int    pos;
		int    pad_lo;
		body = rand_frame_body();
		kind = $urandom_range(0, 11);
		frames_sent++;
		if (kind != 0)
			send_beat(1'b0, CH_HASH);
		case (kind)
			1: begin
				pos = $urandom_range(0, body.len() - 1);
				body[pos] = 8'($urandom_range(0, 255));
				if (body[pos] == CH_HASH || body[pos] == CH_SEMI)
					body[pos] = "x";
				send_text(body);
			end
			2: begin
				pos = $urandom_range(0, body.len());
				send_text(body.substr(0, pos - 1));
				send_beat(1'b0, CH_NUL);
				send_text(body.substr(pos, body.len() - 1));
			end
			3: begin
				// run past the frame limit, or stop right at it
				send_text(body);
				pad_lo = FRAME_LIMIT - 1 - body.len();
				if (pad_lo < 0)
					pad_lo = 0;
				repeat ($urandom_range(pad_lo, pad_lo + 5))
					send_beat(1'b0, ",");
			end
			default: send_text(body);
		endcase
		send_beat(1'b0, CH_SEMI);
	endtask

	initial begin
		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		hold_req = 0;
		beats_sent = 0;
		burst_left = 0;
		frames_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on empty, a byte outside any frame, a restarting '#'
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, 8'hFF);
		send_text("#OK;");
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'h00);
		send_text("#SPD,-9;");
		send_text("#A#HOME;");
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'h00);

		// random: well-formed frames dominate, with pop runs and noise bytes
		while (beats_sent < ITEM_TARGET) begin
			int r;
			r = $urandom_range(0, 9);
			if (beats_sent > 400 && !hold_req)
				hold_req = 1;
			if (r < 6) begin
				send_frame();
			end else if (r < 8) begin
				repeat ($urandom_range(1, 4))
					send_beat(1'b1, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 5))
					send_beat(1'b0, 8'($urandom_range(0, 255)));
			end
		end
		// drain what is queued
		repeat (7)
			send_beat(1'b1, 8'h00);
		push <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d beats, %0d frames; %0d commands popped, %0d dropped on a full ring",
			beats_sent, frames_sent, popped_cmds, dropped_cmds);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
